### hw/rtl/chbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbi_pkg
// types, constants and the crc step shared by the chained hash bucket insert
// ----------------------------------------------------------------------------
package chbi_pkg;

  localparam int unsigned BUCKETS      = 1024;
  localparam int unsigned ENTRIES      = 1024;
  localparam int unsigned PAYLOAD_BITS = 16;

  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam int unsigned ENTRY_W  = $clog2(ENTRIES);
  localparam int unsigned LINK_W   = ENTRY_W + 1;
  localparam int unsigned COUNT_W  = BUCKET_W + 1;

  // link value meaning "no entry"
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(ENTRIES);

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam int unsigned CRC_BYTES = 12;
  localparam int unsigned BYTE_CNT_W = $clog2(CRC_BYTES);

  typedef struct packed {
    logic signed [31:0]       coord_x;
    logic signed [31:0]       coord_y;
    logic signed [31:0]       coord_z;
    logic [PAYLOAD_BITS-1:0]  payload_handle;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  bucket_index;
    logic [9:0]  entry_index;
    logic [10:0] chained_to;
    logic        bucket_newly_used;
    logic [10:0] used_bucket_count;
    logic        pool_full;
  } out_item_t;

  typedef struct packed {
    logic [LINK_W-1:0]       next;
    logic [95:0]             coords;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE,
    ST_EMIT
  } ins_state_e;

  // one byte of the reflected crc-32, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/chained_hash_bucket_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_bucket_insert
// hashes chunk coordinates with crc-32 and links a fresh entry at the head of
// its bucket chain when the pool is not full, tracking the list of buckets in use
// ----------------------------------------------------------------------------
// result path: 12 crc byte steps, one head read, one update, then one output
//   load, which waits while out_stall_i holds the output register
// items are taken one at a time, the crc unit being byte-serial: in_stall_o
//   stays high until the result is loaded; reset: a clearing pass writes
//   "empty" to all 1024 bucket heads, during which in_stall_o stays high
module chained_hash_bucket_insert (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  chbi_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output chbi_pkg::out_item_t  out_data_o
);
  import chbi_pkg::*;

  // memories
  logic [LINK_W-1:0]   head_mem [BUCKETS];
  entry_t              entry_mem [ENTRIES];
  logic [BUCKET_W-1:0] used_mem [BUCKETS];

  // control state
  ins_state_e           state_q, state_d;
  logic [BUCKET_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [BYTE_CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [LINK_W-1:0]    next_free_q, next_free_d;
  logic [COUNT_W-1:0]   used_total_q, used_total_d;
  logic                 out_valid_q, out_valid_d;

  // data path registers
  logic [95:0]             coords_q;
  logic [95:0]             shift_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [31:0]             crc_q;
  logic [LINK_W-1:0]       head_rdata_q;
  out_item_t               res_q, res_d;
  out_item_t               out_q;

  logic                 in_xfer;
  logic                 out_free;
  logic [BUCKET_W-1:0]  bucket;
  logic                 pool_full;
  logic                 head_we;
  logic [BUCKET_W-1:0]  head_waddr;
  logic [LINK_W-1:0]    head_wdata;
  logic                 upd_we;
  logic                 used_we;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // output register can take a new result when empty or being drained
  assign out_free    = !out_valid_q || !out_stall_i;

  // bucket is the low bits of the finished crc (final xor all ones)
  assign bucket    = ~crc_q[BUCKET_W-1:0];
  assign pool_full = (next_free_q == LINK_W'(ENTRIES));

  // next state and control
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    byte_cnt_d   = byte_cnt_q;
    next_free_d  = next_free_q;
    used_total_d = used_total_q;
    out_valid_d  = out_valid_q;
    head_we      = 1'b0;
    head_waddr   = bucket;
    head_wdata   = LINK_W'(next_free_q);
    upd_we       = 1'b0;
    used_we      = 1'b0;
    res_d        = res_q;

    // output register drains on a transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // sweep every bucket head to empty
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
        head_wdata = EMPTY_LINK;
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (clr_cnt_q == BUCKET_W'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          byte_cnt_d = '0;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        byte_cnt_d = byte_cnt_q + 1'b1;
        if (byte_cnt_q == BYTE_CNT_W'(CRC_BYTES - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // head read issued this cycle, data valid next cycle
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        res_d.bucket_index = 10'(bucket);
        if (pool_full) begin
          res_d.entry_index       = '0;
          res_d.chained_to        = 11'(EMPTY_LINK);
          res_d.bucket_newly_used = 1'b0;
          res_d.used_bucket_count = 11'(used_total_q);
          res_d.pool_full         = 1'b1;
        end else begin
          // link new entry at the chain head
          head_we     = 1'b1;
          upd_we      = 1'b1;
          next_free_d = next_free_q + 1'b1;
          // a bucket is in the used list exactly when its chain is non-empty
          if (head_rdata_q == EMPTY_LINK) begin
            used_we      = 1'b1;
            used_total_d = used_total_q + 1'b1;
          end
          res_d.entry_index       = 10'(next_free_q[ENTRY_W-1:0]);
          res_d.chained_to        = 11'(head_rdata_q);
          res_d.bucket_newly_used = (head_rdata_q == EMPTY_LINK);
          res_d.used_bucket_count = 11'(used_total_d);
          res_d.pool_full         = 1'b0;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      byte_cnt_q   <= '0;
      next_free_q  <= '0;
      used_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      byte_cnt_q   <= byte_cnt_d;
      next_free_q  <= next_free_d;
      used_total_q <= used_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // data path registers, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_xfer) begin
      coords_q  <= {in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x};
      shift_q   <= {in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x};
      payload_q <= in_data_i.payload_handle;
      crc_q     <= CRC_INIT;
    end else if (state_q == ST_HASH) begin
      // little-endian bytes, x first
      crc_q   <= crc_byte(crc_q, shift_q[7:0]);
      shift_q <= shift_q >> 8;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

  // bucket head memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata_q <= head_mem[bucket];
  end

  // entry store: successor link, coordinates and payload
  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      entry_mem[next_free_q[ENTRY_W-1:0]] <= '{next: head_rdata_q, coords: coords_q,
                                               payload: payload_q};
    end
  end

  // used-bucket list, appended at the running count
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_total_q[BUCKET_W-1:0]] <= bucket;
    end
  end

endmodule
